### hw/rtl/cefifo_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the coalescing event FIFO.
// No dependencies; used by cefifo_if and by every module except cefifo_ram.
package cefifo_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int OCC_W           = 7;
   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 16;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_TAKE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] RK_PUSH  = 2'd0;
   localparam logic [1:0] RK_EVENT = 2'd1;
   localparam logic [1:0] RK_MARK  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ENTRIES = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_AGE     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MOVE_KIND   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_KIND  = 8'd3;

   localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;
   localparam logic [15:0] MAX_AGE_RST     = 16'd1000;
   localparam logic [3:0]  MOVE_KIND_RST   = 4'd0;
   localparam logic [3:0]  WHEEL_KIND_RST  = 4'd1;

   typedef struct packed {
      logic [3:0]         event_kind;
      logic [7:0]         dev_id;
      logic [7:0]         event_flags;
      logic [7:0]         button_bits;
      logic [7:0]         modifier_bits;
      logic [47:0]        stamp_us;
      logic signed [31:0] delta_a;
      logic signed [31:0] delta_b;
   } entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      entry_type   ev;
      logic [31:0] now_ms;
      logic [6:0]  take_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic             accepted;
      entry_type        ev;
      logic             last;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_TAKE_RD,
      ST_TAKE_OUT,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic flush;
      logic take_start;
      logic push_commit;
      logic take_rd;
      logic pop;
      logic mark;
   } cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] op;
      logic       take_zero;
      logic       slot_free;
      logic       last_pop;
   } status_type;

endpackage

### hw/rtl/cefifo_if.sv
`timescale 1ns / 1ps
// Channel interfaces: request beats, response beats and register writes.
// Depends on cefifo_pkg.
interface cefifo_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [3:0]         event_kind;
   logic [7:0]         dev_id;
   logic [7:0]         event_flags;
   logic [47:0]        stamp_us;
   logic signed [31:0] delta_a;
   logic signed [31:0] delta_b;
   logic [7:0]         button_bits;
   logic [7:0]         modifier_bits;
   logic [31:0]        now_ms;
   logic [6:0]         take_limit;

   modport source (
      output valid, kind, event_kind, dev_id, event_flags, stamp_us,
             delta_a, delta_b, button_bits, modifier_bits, now_ms, take_limit,
      input  ready
   );
   modport sink (
      input  valid, kind, event_kind, dev_id, event_flags, stamp_us,
             delta_a, delta_b, button_bits, modifier_bits, now_ms, take_limit,
      output ready
   );
endinterface

interface cefifo_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    result_kind;
   logic                          accepted;
   logic [3:0]                    out_event_kind;
   logic [7:0]                    out_dev_id;
   logic [7:0]                    out_flags;
   logic [47:0]                   out_stamp_us;
   logic signed [31:0]            out_delta_a;
   logic signed [31:0]            out_delta_b;
   logic [7:0]                    out_buttons;
   logic [7:0]                    out_modifiers;
   logic                          last;
   logic [cefifo_pkg::OCC_W-1:0]  occupancy;

   modport source (
      output valid, result_kind, accepted, out_event_kind, out_dev_id, out_flags,
             out_stamp_us, out_delta_a, out_delta_b, out_buttons, out_modifiers,
             last, occupancy,
      input  ready
   );
   modport sink (
      input  valid, result_kind, accepted, out_event_kind, out_dev_id, out_flags,
             out_stamp_us, out_delta_a, out_delta_b, out_buttons, out_modifiers,
             last, occupancy,
      output ready
   );
endinterface

interface cefifo_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cefifo_pkg::CSR_INDEX_W-1:0] index;
   logic [cefifo_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/cefifo_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cefifo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hw/rtl/cefifo_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for push, take and clear operations.
// Depends on cefifo_pkg; drives commands into cefifo_dp.
module cefifo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  cefifo_pkg::status_type status,
   output cefifo_pkg::cmd_type    cmd
);

   cefifo_pkg::state_type state_ff;
   cefifo_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cefifo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cefifo_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               case (status.op)
                  cefifo_pkg::OP_PUSH:  state_in = cefifo_pkg::ST_PUSH;
                  cefifo_pkg::OP_TAKE:  state_in = status.take_zero ? cefifo_pkg::ST_MARK
                                                                    : cefifo_pkg::ST_TAKE_RD;
                  cefifo_pkg::OP_CLEAR: state_in = cefifo_pkg::ST_MARK;
                  default:              state_in = cefifo_pkg::ST_IDLE;
               endcase
            end
         end
         cefifo_pkg::ST_PUSH: begin
            if (status.slot_free) state_in = cefifo_pkg::ST_IDLE;
         end
         cefifo_pkg::ST_TAKE_RD: begin
            state_in = cefifo_pkg::ST_TAKE_OUT;
         end
         cefifo_pkg::ST_TAKE_OUT: begin
            if (status.slot_free && status.last_pop) state_in = cefifo_pkg::ST_IDLE;
         end
         cefifo_pkg::ST_MARK: begin
            if (status.slot_free) state_in = cefifo_pkg::ST_IDLE;
         end
         default: state_in = cefifo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         cefifo_pkg::ST_IDLE: begin
            cmd.req_ready  = 1'b1;
            cmd.flush      = status.req_valid && (status.op == cefifo_pkg::OP_CLEAR);
            cmd.take_start = status.req_valid && (status.op == cefifo_pkg::OP_TAKE);
         end
         cefifo_pkg::ST_PUSH: begin
            cmd.push_commit = status.slot_free;
         end
         cefifo_pkg::ST_TAKE_RD: begin
            cmd.take_rd = 1'b1;
         end
         cefifo_pkg::ST_TAKE_OUT: begin
            cmd.take_rd = 1'b1;
            cmd.pop     = status.slot_free;
         end
         cefifo_pkg::ST_MARK: begin
            cmd.mark = status.slot_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### hw/rtl/cefifo_dp.sv
`timescale 1ns / 1ps
// Datapath: entry RAMs, ring pointers, coalesce/age logic, config and output register.
// Depends on cefifo_pkg, cefifo_if and cefifo_ram.
module cefifo_dp #(
   parameter int QUEUE_DEPTH = cefifo_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   cefifo_req_if.sink             req,
   cefifo_rsp_if.source           rsp,
   cefifo_csr_if.sink             csr,
   input  cefifo_pkg::cmd_type    cmd,
   output cefifo_pkg::status_type status
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W = cefifo_pkg::OCC_W;

   logic [6:0]  max_entries_ff;
   logic [15:0] max_age_ff;
   logic [3:0]  move_kind_ff;
   logic [3:0]  wheel_kind_ff;

   cefifo_pkg::req_type req_ff, req_in;
   cefifo_pkg::rsp_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in, remain_ff, remain_in;

   logic [IDX_W-1:0] head_next, tail_next, newest;
   logic [IDX_W-1:0] main_rd_addr, main_wr_addr;
   logic             main_wr_en, arr_wr_en;
   cefifo_pkg::entry_type main_rd, main_wr;
   logic [31:0]      arr_rd;

   logic [OCC_W-1:0] count7, lim7, take_n7;
   logic [31:0]      age, age_lim;
   logic             merge, stale, full, drop, append;
   logic [32:0]      sum_a, sum_b;
   logic signed [31:0] sat_a, sat_b;
   logic             accept;

   // ring arithmetic
   assign head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign newest    = (tail_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_ff - 1'b1;

   assign count7  = OCC_W'(count_ff);
   assign lim7    = (max_entries_ff == '0) ? OCC_W'(1)
                  : ((max_entries_ff > OCC_W'(QUEUE_DEPTH)) ? OCC_W'(QUEUE_DEPTH)
                                                           : max_entries_ff);
   assign take_n7 = (req.take_limit < count7) ? req.take_limit : count7;

   assign accept = req.valid && cmd.req_ready;

   // handshake
   assign req.ready = cmd.req_ready;
   assign csr.ready = 1'b1;

   assign status.req_valid = req.valid;
   assign status.op        = req.kind;
   assign status.take_zero = (take_n7 == '0);
   assign status.slot_free = !rsp_valid_ff || rsp.ready;
   assign status.last_pop  = (remain_ff == CNT_W'(1));

   // push decision
   assign merge = (count_ff != '0)
               && (main_rd.event_kind == req_ff.ev.event_kind)
               && (main_rd.dev_id == req_ff.ev.dev_id)
               && (main_rd.event_flags == req_ff.ev.event_flags)
               && ((main_rd.event_kind == move_kind_ff) || (main_rd.event_kind == wheel_kind_ff));
   assign age     = req_ff.now_ms - arr_rd;
   assign age_lim = (max_age_ff == '0) ? 32'd1 : 32'(max_age_ff);
   assign stale   = (count_ff != '0) && (age > age_lim);
   assign full    = (count7 >= lim7);
   assign drop    = !merge && (full || stale);
   assign append  = !merge && !drop;

   assign sum_a = {main_rd.delta_a[31], main_rd.delta_a} + {req_ff.ev.delta_a[31], req_ff.ev.delta_a};
   assign sum_b = {main_rd.delta_b[31], main_rd.delta_b} + {req_ff.ev.delta_b[31], req_ff.ev.delta_b};
   assign sat_a = (sum_a[32] != sum_a[31]) ? (sum_a[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                           : sum_a[31:0];
   assign sat_b = (sum_b[32] != sum_b[31]) ? (sum_b[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                           : sum_b[31:0];

   // RAM ports
   always_comb begin
      main_wr         = req_ff.ev;
      main_wr_addr    = tail_ff;
      if (merge) begin
         main_wr.delta_a = sat_a;
         main_wr.delta_b = sat_b;
         main_wr_addr    = newest;
      end
      main_wr_en   = cmd.push_commit && (merge || append);
      arr_wr_en    = cmd.push_commit && append;
      main_rd_addr = cmd.take_rd ? (cmd.pop ? head_next : head_ff) : newest;
   end

   cefifo_ram #(
      .WIDTH ($bits(cefifo_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (main_wr_en),
      .wr_addr (main_wr_addr),
      .wr_data (main_wr),
      .rd_addr (main_rd_addr),
      .rd_data (main_rd)
   );

   cefifo_ram #(
      .WIDTH (32),
      .DEPTH (QUEUE_DEPTH)
   ) u_arrival_ram (
      .clock   (clock),
      .wr_en   (arr_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_ff.now_ms),
      .rd_addr (head_ff),
      .rd_data (arr_rd)
   );

   // request capture
   always_comb begin
      req_in                  = req_ff;
      if (accept) begin
         req_in.kind             = req.kind;
         req_in.ev.event_kind    = req.event_kind;
         req_in.ev.dev_id        = req.dev_id;
         req_in.ev.event_flags   = req.event_flags;
         req_in.ev.button_bits   = req.button_bits;
         req_in.ev.modifier_bits = req.modifier_bits;
         req_in.ev.stamp_us      = req.stamp_us;
         req_in.ev.delta_a       = req.delta_a;
         req_in.ev.delta_b       = req.delta_b;
         req_in.now_ms           = req.now_ms;
         req_in.take_limit       = req.take_limit;
      end
   end

   // pointers, counters and response register
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (cmd.flush) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
      if (cmd.take_start) begin
         remain_in = CNT_W'(take_n7);
      end

      if (cmd.push_commit) begin
         rsp_in             = '0;
         rsp_in.result_kind = cefifo_pkg::RK_PUSH;
         rsp_in.accepted    = !drop;
         rsp_in.last        = 1'b1;
         rsp_valid_in       = 1'b1;
         if (drop) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end else if (append) begin
            tail_in  = tail_next;
            count_in = count_ff + 1'b1;
         end
         rsp_in.occupancy = OCC_W'(count_in);
      end

      if (cmd.pop) begin
         head_in            = head_next;
         count_in           = count_ff - 1'b1;
         remain_in          = remain_ff - 1'b1;
         rsp_in             = '0;
         rsp_in.result_kind = cefifo_pkg::RK_EVENT;
         rsp_in.ev          = main_rd;
         rsp_in.last        = (remain_ff == CNT_W'(1));
         rsp_in.occupancy   = OCC_W'(count_in);
         rsp_valid_in       = 1'b1;
      end

      if (cmd.mark) begin
         rsp_in             = '0;
         rsp_in.result_kind = cefifo_pkg::RK_MARK;
         rsp_in.last        = 1'b1;
         rsp_in.occupancy   = OCC_W'(count_ff);
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         remain_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= cefifo_pkg::MAX_ENTRIES_RST;
         max_age_ff     <= cefifo_pkg::MAX_AGE_RST;
         move_kind_ff   <= cefifo_pkg::MOVE_KIND_RST;
         wheel_kind_ff  <= cefifo_pkg::WHEEL_KIND_RST;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            unique case (csr.index)
               cefifo_pkg::REG_MAX_ENTRIES: max_entries_ff <= csr.data[6:0];
               cefifo_pkg::REG_MAX_AGE:     max_age_ff     <= csr.data[15:0];
               cefifo_pkg::REG_MOVE_KIND:   move_kind_ff   <= csr.data[3:0];
               cefifo_pkg::REG_WHEEL_KIND:  wheel_kind_ff  <= csr.data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_kind    = rsp_ff.result_kind;
   assign rsp.accepted       = rsp_ff.accepted;
   assign rsp.out_event_kind = rsp_ff.ev.event_kind;
   assign rsp.out_dev_id     = rsp_ff.ev.dev_id;
   assign rsp.out_flags      = rsp_ff.ev.event_flags;
   assign rsp.out_stamp_us   = rsp_ff.ev.stamp_us;
   assign rsp.out_delta_a    = rsp_ff.ev.delta_a;
   assign rsp.out_delta_b    = rsp_ff.ev.delta_b;
   assign rsp.out_buttons    = rsp_ff.ev.button_bits;
   assign rsp.out_modifiers  = rsp_ff.ev.modifier_bits;
   assign rsp.last           = rsp_ff.last;
   assign rsp.occupancy      = rsp_ff.occupancy;

endmodule

### hw/rtl/coalescing_event_fifo.sv
`timescale 1ns / 1ps
// Coalescing event FIFO top level: a push, a clear and an empty take each give one
// response beat; a take first reads the head entry and then gives one event per
// cycle while rsp is ready (registered RAM read).
// A push reads the newest entry and the oldest arrival time, then merges, appends or drops (a drop empties the queue).
// Synchronous reset clears pointers, count and state and loads register defaults;
// entry RAM contents are not cleared. Depends on cefifo_pkg, cefifo_if, cefifo_ctrl, cefifo_dp.
module coalescing_event_fifo #(
   parameter int QUEUE_DEPTH = cefifo_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   cefifo_req_if.sink   req_ch,
   cefifo_rsp_if.source rsp_ch,
   cefifo_csr_if.sink   csr_ch
);

   cefifo_pkg::cmd_type    cmd;
   cefifo_pkg::status_type status;

   cefifo_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   cefifo_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .csr    (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule
